[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEAVES_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int REQ_W    = 6;
    localparam int OFF_W    = 6;
    localparam int STATUS_W = 2;
    localparam int BOFF_W   = 5;
    localparam int BUNITS_W = 6;
    // rounded request: up to 64 units
    localparam int WANT_W   = REQ_W + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_SIZE  = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_SPACE = 2'd1,
        STAT_BAD      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AL_ROOT,
        S_AL_DOWN,
        S_MARK,
        S_UP_RD,
        S_UP_WR,
        S_FIND,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BOFF_W-1:0]   block_offset;
        logic [BUNITS_W-1:0] block_units;
    } result_t;

    // next power of two at or above req, 0 counts as 1
    function automatic logic [WANT_W-1:0] round_up_pow2(input logic [REQ_W-1:0] req);
        logic [WANT_W-1:0] w;
        w = WANT_W'(1);
        for (int k = 0; k < REQ_W; k++) begin
            if (w < {1'b0, req}) begin
                w = {w[WANT_W-2:0], 1'b0};
            end
        end
        return w;
    endfunction

endpackage

[rtl/bba_node_ram.sv]
// ----------------------------------------------------------------------------
// bba_node_ram
// Node store of the buddy tree: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_node_ram
    import bba_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(2*LEAVES)-1:0]  wr_addr,
    input  logic [$clog2(LEAVES):0]      wr_data,
    input  logic [$clog2(2*LEAVES)-1:0]  rd_addr,
    output logic [$clog2(LEAVES):0]      rd_data
);

    localparam int NODES = 2 * LEAVES - 1;
    localparam int VW    = $clog2(LEAVES) + 1;

    logic [VW-1:0] mem [NODES];
    logic [VW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bba_alu.sv]
// ----------------------------------------------------------------------------
// bba_alu
// Shared compare / merge unit: fit test against the rounded request and the
// parent value from two child values (max, or full merge on free).
// ----------------------------------------------------------------------------
module bba_alu
    import bba_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic [$clog2(LEAVES):0] node_val,
    input  logic [$clog2(LEAVES):0] cur_val,
    input  logic [WANT_W-1:0]       want,
    input  logic [$clog2(LEAVES):0] parent_size,
    input  logic                    merge_en,
    output logic                    fit,
    output logic [$clog2(LEAVES):0] parent_val
);

    localparam int VW = $clog2(LEAVES) + 1;
    localparam int CW = (VW > WANT_W) ? VW : WANT_W;

    logic [VW:0]   sum;
    logic [VW-1:0] max_val;

    always_comb begin
        fit     = CW'(node_val) >= CW'(want);
        sum     = {1'b0, node_val} + {1'b0, cur_val};
        max_val = (node_val > cur_val) ? node_val : cur_val;
        // both buddies fully free: they join into the parent block
        if (merge_en && (sum == {1'b0, parent_size})) begin
            parent_val = parent_size;
        end else begin
            parent_val = max_val;
        end
    end

endmodule

[rtl/bba_seq.sv]
// ----------------------------------------------------------------------------
// bba_seq
// Sequencer: clearing pass, tree descent for alloc, leaf climb for free and
// size, and the ancestor update walk, one node access per step.
// ----------------------------------------------------------------------------
module bba_seq
    import bba_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [OPCODE_W-1:0]          opcode,
    input  logic [REQ_W-1:0]             request_units,
    input  logic [OFF_W-1:0]             unit_offset,
    input  logic                         out_free,
    output logic                         res_valid,
    output result_t                      res,
    output logic                         wr_en,
    output logic [$clog2(2*LEAVES)-1:0]  wr_addr,
    output logic [$clog2(LEAVES):0]      wr_data,
    output logic [$clog2(2*LEAVES)-1:0]  rd_addr,
    input  logic [$clog2(LEAVES):0]      rd_data
);

    localparam int W  = $clog2(LEAVES);
    localparam int VW = W + 1;
    localparam int NW = $clog2(2 * LEAVES);
    localparam int XW = ((OFF_W > NW) ? OFF_W : NW) + 1;
    localparam logic [NW-1:0] LAST_NODE  = NW'(2 * LEAVES - 2);
    localparam logic [NW-1:0] LEAF_BASE  = NW'(LEAVES - 1);
    localparam logic [VW-1:0] ROOT_SIZE  = VW'(LEAVES);
    localparam int CW = (VW > WANT_W) ? VW : WANT_W;

    state_t              state_reg, state_next;
    logic [NW-1:0]       idx_reg, idx_next;
    logic [VW-1:0]       sz_reg, sz_next;
    logic [VW-1:0]       cur_reg, cur_next;
    logic [VW-1:0]       unit_reg, unit_next;
    logic [W-1:0]        off_reg, off_next;
    logic [WANT_W-1:0]   want_reg, want_next;
    logic                free_reg, free_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                fit;
    logic [VW-1:0]       parent_val;
    logic [VW-1:0]       sz_up;
    logic [VW-1:0]       sz_down;
    logic [NW-1:0]       parent_idx;
    logic [NW-1:0]       left_idx;
    logic [NW-1:0]       down_idx;
    logic [NW:0]         idx_p1;
    logic [NW:0]         idx_p2;

    assign sz_up      = {sz_reg[VW-2:0], 1'b0};
    assign sz_down    = {1'b0, sz_reg[VW-1:1]};
    assign parent_idx = (idx_reg - NW'(1)) >> 1;
    assign left_idx   = {idx_reg[NW-2:0], 1'b1};
    assign down_idx   = fit ? left_idx : (left_idx + NW'(1));
    assign idx_p1     = {1'b0, idx_reg} + (NW+1)'(1);
    assign idx_p2     = {1'b0, idx_reg} + (NW+1)'(2);

    bba_alu #(
        .LEAVES (LEAVES)
    ) u_alu (
        .node_val    (rd_data),
        .cur_val     (cur_reg),
        .want        (want_reg),
        .parent_size (sz_up),
        .merge_en    (free_reg),
        .fit         (fit),
        .parent_val  (parent_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            sz_reg    <= ROOT_SIZE;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sz_reg    <= sz_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        unit_reg   <= unit_next;
        off_reg    <= off_next;
        want_reg   <= want_next;
        free_reg   <= free_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        sz_next     = sz_reg;
        cur_next    = cur_reg;
        unit_next   = unit_reg;
        off_next    = off_reg;
        want_next   = want_reg;
        free_next   = free_reg;
        status_next = status_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '0;
        rd_addr     = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // node i gets LEAVES >> depth(i); halve at each level start
                wr_en    = 1'b1;
                wr_data  = sz_reg;
                idx_next = idx_reg + NW'(1);
                if ((idx_p1 & idx_p2) == '0) begin
                    sz_next = sz_down;
                end
                if (idx_reg == LAST_NODE) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    off_next    = '0;
                    unit_next   = '0;
                    status_next = STAT_BAD;
                    want_next   = round_up_pow2(request_units);
                    free_next   = (opcode == OP_FREE);
                    priority if (opcode == OP_ALLOC) begin
                        idx_next   = '0;
                        sz_next    = ROOT_SIZE;
                        rd_addr    = '0;
                        state_next = S_AL_ROOT;
                    end else if (((opcode == OP_FREE) || (opcode == OP_SIZE))
                                 && (XW'(unit_offset) < XW'(LEAVES))) begin
                        idx_next   = NW'(unit_offset) + LEAF_BASE;
                        sz_next    = VW'(1);
                        rd_addr    = NW'(unit_offset) + LEAF_BASE;
                        state_next = S_FIND;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_AL_ROOT: begin
                priority if (!fit) begin
                    status_next = STAT_NO_SPACE;
                    state_next  = S_RESULT;
                end else if (CW'(sz_reg) > CW'(want_reg)) begin
                    rd_addr    = left_idx;
                    state_next = S_AL_DOWN;
                end else begin
                    state_next = S_MARK;
                end
            end

            S_AL_DOWN: begin
                // rd_data is the left child; leftmost fit wins
                idx_next = down_idx;
                sz_next  = sz_down;
                if (!fit) begin
                    off_next = off_reg + W'(sz_down);
                end
                if (CW'(sz_down) > CW'(want_reg)) begin
                    rd_addr = {down_idx[NW-2:0], 1'b1};
                end else begin
                    state_next = S_MARK;
                end
            end

            S_MARK: begin
                wr_en       = 1'b1;
                wr_data     = '0;
                cur_next    = '0;
                unit_next   = sz_reg;
                status_next = STAT_OK;
                state_next  = (idx_reg == '0) ? S_RESULT : S_UP_RD;
            end

            S_UP_RD: begin
                // odd index is a left child, buddy sits to its right
                rd_addr    = idx_reg[0] ? (idx_reg + NW'(1)) : (idx_reg - NW'(1));
                state_next = S_UP_WR;
            end

            S_UP_WR: begin
                wr_en      = 1'b1;
                wr_addr    = parent_idx;
                wr_data    = parent_val;
                cur_next   = parent_val;
                idx_next   = parent_idx;
                sz_next    = sz_up;
                state_next = (parent_idx == '0) ? S_RESULT : S_UP_RD;
            end

            S_FIND: begin
                if (rd_data != '0) begin
                    if (idx_reg == '0) begin
                        state_next = S_RESULT;
                    end else begin
                        idx_next = parent_idx;
                        sz_next  = sz_up;
                        rd_addr  = parent_idx;
                    end
                end else begin
                    status_next = STAT_OK;
                    unit_next   = sz_reg;
                    if (free_reg) begin
                        wr_en      = 1'b1;
                        wr_data    = sz_reg;
                        cur_next   = sz_reg;
                        state_next = (idx_reg == '0) ? S_RESULT : S_UP_RD;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status       = status_reg;
    assign res.block_offset = BOFF_W'(off_reg);
    assign res.block_units  = BUNITS_W'(unit_reg);

endmodule

[rtl/buddy_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Buddy allocator over a pool of LEAVES units, kept as a binary tree of
// largest-free-block values in a single-port-read node RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                        Moves
//  --------  -------------------------------------------  ----------------------
//  s_        s_valid/s_ready, s_opcode, s_request_units,  one request per op
//            s_unit_offset
//  m_        m_valid/m_ready, m_status, m_block_offset,   one result per request
//            m_block_units
//
//  Steps: alloc reads the root, descends to the leftmost fit, marks the
//  chosen node and walks up, reading each buddy, then writing the parent;
//  out of space stops at the root; free climbs from the leaf to the used
//  node, restores it and walks up; size only climbs; errors go straight
//  to the result. The node RAM gives one read and one write per cycle.
//  Reset: a clearing pass writes all 2*LEAVES-1 nodes, one per cycle,
//  before s_ready first rises.
//  Stalls: a new request is taken while the last result waits in the output
//  register; the next result holds in the sequencer until that one leaves.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OPCODE_W-1:0] s_opcode,
    input  logic [REQ_W-1:0]    s_request_units,
    input  logic [OFF_W-1:0]    s_unit_offset,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [BOFF_W-1:0]   m_block_offset,
    output logic [BUNITS_W-1:0] m_block_units
);

    localparam int VW = $clog2(LEAVES) + 1;
    localparam int NW = $clog2(2 * LEAVES);

    // node RAM port
    logic          wr_en;
    logic [NW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
    logic [NW-1:0] rd_addr;
    logic [VW-1:0] rd_data;

    // sequencer to output stage
    logic    res_valid;
    result_t res;
    logic    out_free;

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    bba_node_ram #(
        .LEAVES (LEAVES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bba_seq #(
        .LEAVES (LEAVES)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (s_valid),
        .req_ready     (s_ready),
        .opcode        (s_opcode),
        .request_units (s_request_units),
        .unit_offset   (s_unit_offset),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_res_reg.status;
    assign m_block_offset = m_res_reg.block_offset;
    assign m_block_units  = m_res_reg.block_units;

endmodule

[tb/bba_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// bba_scoreboard_pkg
// Tree-based predictor and in-order result checker for the buddy allocator.
// ----------------------------------------------------------------------------
package bba_scoreboard_pkg;
    import bba_pkg::*;

    localparam int LEAVES = LEAVES_DEF;
    localparam int NODES  = 2 * LEAVES - 1;

    // opcode with no operation behind it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        int start;
        int units;
    } live_block_t;

    class buddy_scoreboard;
        // largest free power-of-two block inside each node's span
        logic [BUNITS_W-1:0] free_span [NODES];
        result_t             expected_q [$];
        live_block_t         live_blocks [$];
        int requests;
        int results_seen;
        int mismatches;
        int op_count [4];
        int status_count [3];

        function new();
            int span;
            span = 2 * LEAVES;
            for (int i = 0; i < NODES; i++) begin
                if (((i + 1) & i) == 0) span = span / 2;
                free_span[i] = BUNITS_W'(span);
            end
            requests     = 0;
            results_seen = 0;
            mismatches   = 0;
            foreach (op_count[i]) op_count[i] = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        // apply one accepted request to the tree and queue its result
        function void note_request(logic [OPCODE_W-1:0] op, logic [REQ_W-1:0] req,
                                   logic [OFF_W-1:0] off);
            result_t           res;
            logic [WANT_W-1:0] want;
            int                node;
            int                span;
            int                start;
            int                lsum;
            res        = '0;
            res.status = STAT_BAD;
            requests++;
            op_count[op]++;
            case (op)
                OP_ALLOC: begin
                    want = WANT_W'(1);
                    while (want < req) want = want << 1;
                    if (free_span[0] < want) begin
                        res.status = STAT_NO_SPACE;
                    end else begin
                        // leftmost fit on the way down
                        node = 0;
                        span = LEAVES;
                        while (span > int'(want) && node < LEAVES - 1) begin
                            node = 2 * node + 1;
                            if (free_span[node] < want) node++;
                            span = span / 2;
                        end
                        free_span[node]  = '0;
                        start            = (node + 1) * span - LEAVES;
                        res.status       = STAT_OK;
                        res.block_offset = BOFF_W'(start);
                        res.block_units  = BUNITS_W'(span);
                        live_blocks.push_back('{start: start, units: span});
                        while (node != 0) begin
                            node = (node - 1) / 2;
                            free_span[node] = (free_span[2*node+1] > free_span[2*node+2]) ?
                                              free_span[2*node+1] : free_span[2*node+2];
                        end
                    end
                end
                OP_FREE, OP_SIZE: begin
                    if (off < LEAVES) begin
                        // climb to the used node covering the offset
                        node = int'(off) + LEAVES - 1;
                        span = 1;
                        while (free_span[node] != 0 && node != 0) begin
                            node = (node - 1) / 2;
                            span = span * 2;
                        end
                        if (free_span[node] == 0) begin
                            res.status      = STAT_OK;
                            res.block_units = BUNITS_W'(span);
                            if (op == OP_FREE) begin
                                start = (node + 1) * span - LEAVES;
                                for (int i = live_blocks.size() - 1; i >= 0; i--)
                                    if (live_blocks[i].start == start) live_blocks.delete(i);
                                free_span[node] = BUNITS_W'(span);
                                // merge buddies on the way up
                                while (node != 0) begin
                                    node = (node - 1) / 2;
                                    span = span * 2;
                                    lsum = int'(free_span[2*node+1]) + int'(free_span[2*node+2]);
                                    if (lsum == span)
                                        free_span[node] = BUNITS_W'(span);
                                    else
                                        free_span[node] = (free_span[2*node+1] >
                                                           free_span[2*node+2]) ?
                                                          free_span[2*node+1] :
                                                          free_span[2*node+2];
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
            status_count[res.status]++;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [BOFF_W-1:0] boff,
                                   logic [BUNITS_W-1:0] bunits);
            result_t want_res;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d with no request pending: status %0d offset %0d units %0d",
                             results_seen, status, boff, bunits);
                return;
            end
            want_res = expected_q.pop_front();
            if (status !== want_res.status || boff !== want_res.block_offset ||
                bunits !== want_res.block_units) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected status %0d offset %0d units %0d, got status %0d offset %0d units %0d",
                             results_seen, want_res.status, want_res.block_offset,
                             want_res.block_units, status, boff, bunits);
            end
        endfunction
    endclass

endpackage

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for buddy_block_allocator_top: directed corner requests,
// then random allocate/free/query traffic with bursty input, a stalling
// output and one long output hold-off; every result checked in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;
    import bba_scoreboard_pkg::*;

    localparam int RANDOM_REQUESTS = 1500;
    // the hold-off below is the longest quiet stretch
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_AFTER  = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode        = '0;
    logic [REQ_W-1:0]    s_request_units = '0;
    logic [OFF_W-1:0]    s_unit_offset   = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [BOFF_W-1:0]   m_block_offset;
    logic [BUNITS_W-1:0] m_block_units;

    buddy_scoreboard alloc_sb = new();

    int burst_left   = 1;
    int quiet_cycles = 0;

    buddy_block_allocator_top #(
        .LEAVES(LEAVES)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_request_units (s_request_units),
        .s_unit_offset   (s_unit_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_offset  (m_block_offset),
        .m_block_units   (m_block_units)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Present one request and hold it until accepted, then note it with the
    // predictor. At the end of a burst the sender may go quiet for a while.
    // valid stays high across back-to-back requests (single NBA per edge).
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic [REQ_W-1:0]    req,
                                input logic [OFF_W-1:0]    off);
        int gap;
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_request_units <= req;
        s_unit_offset   <= off;
        do @(posedge aclk); while (!s_ready);
        alloc_sb.note_request(op, req, off);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Some offset inside a block that is currently allocated; a random
    // offset over the whole field when nothing is live.
    function automatic logic [OFF_W-1:0] offset_in_live_block();
        live_block_t blk;
        if (alloc_sb.live_blocks.size() == 0) return OFF_W'($urandom);
        blk = alloc_sb.live_blocks[$urandom_range(0, alloc_sb.live_blocks.size() - 1)];
        return OFF_W'(blk.start + $urandom_range(0, blk.units - 1));
    endfunction

    // Stimulus: directed corners first, then random traffic.
    initial begin
        int                  pick;
        logic [OPCODE_W-1:0] op;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // empty pool: nothing allocated anywhere
        send_request(OP_SIZE,   6'd0,  6'd0);
        send_request(OP_FREE,   6'd63, 6'd31);
        // zero request rounds to one unit
        send_request(OP_ALLOC,  6'd0,  6'd0);
        // requests larger than the pool, and the whole pool when partly used
        send_request(OP_ALLOC,  6'd33, 6'd0);
        send_request(OP_ALLOC,  6'd63, 6'd63);
        send_request(OP_ALLOC,  6'd32, 6'd0);
        send_request(OP_FREE,   6'd0,  6'd0);
        // whole pool as one block; any offset inside finds it
        send_request(OP_ALLOC,  6'd32, 6'd0);
        send_request(OP_SIZE,   6'd0,  6'd31);
        send_request(OP_ALLOC,  6'd1,  6'd0);
        send_request(OP_FREE,   6'd0,  6'd17);
        // offsets past the pool
        send_request(OP_FREE,   6'd0,  6'd32);
        send_request(OP_SIZE,   6'd63, 6'd63);
        send_request(OP_UNUSED, 6'd63, 6'd63);
        // mixed sizes packed leftmost, then a hole that is not allocated
        send_request(OP_ALLOC,  6'd3,  6'd0);
        send_request(OP_ALLOC,  6'd1,  6'd0);
        send_request(OP_ALLOC,  6'd2,  6'd0);
        send_request(OP_ALLOC,  6'd16, 6'd0);
        send_request(OP_SIZE,   6'd0,  6'd5);
        // free from inside each block; buddies merge back to a full pool
        send_request(OP_FREE,   6'd0,  6'd2);
        send_request(OP_FREE,   6'd0,  6'd4);
        send_request(OP_FREE,   6'd0,  6'd7);
        send_request(OP_FREE,   6'd0,  6'd20);
        send_request(OP_ALLOC,  6'd0,  6'd63);

        // Random traffic: mostly allocations and frees of live blocks so the
        // tree fragments and merges; the rest is size queries of live blocks,
        // bad offsets, holes, unused opcodes and large requests.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_request(OP_ALLOC,
                             ($urandom_range(0, 6) != 0) ? REQ_W'($urandom_range(0, 8))
                                                         : REQ_W'($urandom),
                             OFF_W'($urandom));
            end else if (pick < 65) begin
                send_request(OP_FREE, REQ_W'($urandom), offset_in_live_block());
            end else if (pick < 75) begin
                send_request(OP_SIZE, REQ_W'($urandom), offset_in_live_block());
            end else if (pick < 92) begin
                op = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_SIZE;
                send_request(op, REQ_W'($urandom), OFF_W'($urandom));
            end else if (pick < 96) begin
                send_request(OP_UNUSED, REQ_W'($urandom), OFF_W'($urandom));
            end else begin
                send_request(OP_ALLOC, REQ_W'($urandom_range(17, 63)), OFF_W'($urandom));
            end
        end
        s_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (alloc_sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d allocate, %0d free, %0d size query, %0d unused opcode",
                 alloc_sb.requests, alloc_sb.op_count[OP_ALLOC], alloc_sb.op_count[OP_FREE],
                 alloc_sb.op_count[OP_SIZE], alloc_sb.op_count[OP_UNUSED]);
        $display("Outcomes: %0d ok, %0d out of space, %0d bad or unallocated; %0d results, %0d mismatches",
                 alloc_sb.status_count[STAT_OK], alloc_sb.status_count[STAT_NO_SPACE],
                 alloc_sb.status_count[STAT_BAD], alloc_sb.results_seen, alloc_sb.mismatches);
        if (alloc_sb.mismatches == 0 && alloc_sb.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver: the stall pattern is redrawn whenever its random run ends. Once, well
    // into the run, ready is held low long enough for the output register
    // and the sequencer to fill so that s_ready drops under load.
    initial begin
        rx_mode_t mode;
        int       mode_left;
        bit       held_off;
        mode      = RX_ALWAYS;
        mode_left = 0;
        held_off  = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held_off && alloc_sb.requests >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= ($urandom_range(0, 1) != 0);
                    RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ((mode_left % 5) < 2);
                endcase
            end
        end
    end

    // Result monitor and watchdog; values read here are the pre-edge ones
    // the block itself sampled.
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            alloc_sb.check_result(m_status, m_block_offset, m_block_units);
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no request or result moved for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, alloc_sb.expected_q.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

[sim.f]
rtl/bba_pkg.sv
rtl/bba_node_ram.sv
rtl/bba_alu.sv
rtl/bba_seq.sv
rtl/buddy_block_allocator_top.sv
tb/bba_scoreboard_pkg.sv
tb/tb.sv
